FILE: rtl/core/pps_pkg.sv
// shared widths, constants and types for the positional pid speed step
`default_nettype none
package pps_pkg;

    localparam int GAIN_W  = 10;
    localparam int SET_W   = 10;
    localparam int ACT_W   = 24;
    localparam int ERR_W   = 25;
    localparam int PREV_W  = 26;
    localparam int DIFF_W  = 26;
    localparam int TOT_W   = 32;
    localparam int DRV_W   = 32;
    localparam int SUM_W   = 44;
    localparam int MUL_B_W = 11;
    localparam int ACC_W   = SUM_W + MUL_B_W;
    localparam int NUM_W   = 52;
    localparam int DIV_W   = 52;
    localparam int CFG_AW  = 2;

    // divider datapath: magnitudes are clipped where the quotient saturates anyway
    localparam int NP_W     = 31;
    localparam int ND_W     = 46;
    localparam int LO_W     = 18;
    localparam int HI_W     = ND_W - LO_W;
    localparam int QP_W     = 25;
    localparam int QH_W     = 15;
    localparam int QL_W     = 18;
    localparam int RD_W     = 14;
    localparam int MUL_AW   = 32;
    localparam int MUL_BW   = 33;
    localparam int MUL_PW   = MUL_AW + MUL_BW;
    localparam int RCP_P_SH = 38;
    localparam int RCP_D_SH = 46;

    // drive = (sum_h * 663 + 250 * 11800) / 11800, pid = sum_h / 100
    localparam logic [MUL_B_W-1:0] SCALE_NUM = 11'd663;
    localparam logic [ACC_W-1:0]   DRV_OFS   = 55'd2950000;

    // ceil(2^38 / 100) and ceil(2^46 / 11800), exact for dividends below 2^31 and 2^32
    localparam logic [MUL_BW-1:0] RCP_PID = 33'd2748779070;
    localparam logic [MUL_BW-1:0] RCP_DRV = 33'd5963452897;
    localparam logic [MUL_BW-1:0] DRV_DEN = 33'd11800;

    localparam logic [CFG_AW-1:0] REG_GAIN_PROP  = 2'd0;
    localparam logic [CFG_AW-1:0] REG_GAIN_INTEG = 2'd1;
    localparam logic [CFG_AW-1:0] REG_GAIN_DERIV = 2'd2;

    typedef struct packed {
        logic load;
        logic accum;
    } mac_ctl_t;

endpackage
`default_nettype wire

FILE: rtl/core/pps_mac.sv
// shared signed multiply-accumulate unit
`default_nettype none
module pps_mac (
    input  wire logic                                aclk,
    input  wire pps_pkg::mac_ctl_t                   ctl,
    input  wire logic signed [pps_pkg::SUM_W-1:0]    op_a,
    input  wire logic signed [pps_pkg::MUL_B_W-1:0]  op_b,
    input  wire logic signed [pps_pkg::ACC_W-1:0]    addend,
    output logic signed [pps_pkg::ACC_W-1:0]         acc
);
    import pps_pkg::*;

    logic signed [ACC_W-1:0] prod;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;

    assign prod = op_a * op_b;

    always_comb begin
        acc_next = acc_reg;
        if (ctl.load) begin
            acc_next = prod + addend;
        end else if (ctl.accum) begin
            acc_next = acc_reg + prod;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule
`default_nettype wire

FILE: rtl/core/pps_div.sv
// reciprocal-multiply divider by the constants 100 and 11800, four steps on one multiplier
`default_nettype none
module pps_div (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [pps_pkg::DIV_W-1:0]   dvd_pid,
    input  wire logic [pps_pkg::DIV_W-1:0]   dvd_drv,
    output logic                             done,
    output logic [pps_pkg::DIV_W-1:0]        quo_pid,
    output logic [pps_pkg::DIV_W-1:0]        quo_drv
);
    import pps_pkg::*;

    localparam logic [1:0] ST_PID  = 2'd0;
    localparam logic [1:0] ST_HIGH = 2'd1;
    localparam logic [1:0] ST_REM  = 2'd2;
    localparam logic [1:0] ST_LOW  = 2'd3;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [1:0]        step_reg, step_next;
    logic [NP_W-1:0]   np_reg, np_next;
    logic [HI_W-1:0]   hi_reg, hi_next;
    logic [LO_W-1:0]   lo_reg, lo_next;
    logic [QP_W-1:0]   qp_reg, qp_next;
    logic [QH_W-1:0]   qh_reg, qh_next;
    logic [QL_W-1:0]   ql_reg, ql_next;
    logic [RD_W-1:0]   rem_reg, rem_next;
    logic [MUL_AW-1:0] mul_a;
    logic [MUL_BW-1:0] mul_b;
    logic [MUL_PW-1:0] prod;
    logic [HI_W-1:0]   hi_rem;
    logic [ND_W-1:0]   nd_clip;

    // clipped dividends still give quotients beyond the saturation limits
    assign nd_clip = (|dvd_drv[DIV_W-1:ND_W]) ? '1 : dvd_drv[ND_W-1:0];

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (step_reg)
            ST_PID: begin
                mul_a = MUL_AW'(np_reg);
                mul_b = RCP_PID;
            end
            ST_HIGH: begin
                mul_a = MUL_AW'(hi_reg);
                mul_b = RCP_DRV;
            end
            ST_REM: begin
                mul_a = MUL_AW'(qh_reg);
                mul_b = DRV_DEN;
            end
            ST_LOW: begin
                mul_a = {rem_reg, lo_reg};
                mul_b = RCP_DRV;
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    assign prod   = MUL_PW'(mul_a) * MUL_PW'(mul_b);
    assign hi_rem = hi_reg - prod[HI_W-1:0];

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        np_next   = np_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        qp_next   = qp_reg;
        qh_next   = qh_reg;
        ql_next   = ql_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = ST_PID;
            np_next   = (|dvd_pid[DIV_W-1:NP_W]) ? '1 : dvd_pid[NP_W-1:0];
            hi_next   = nd_clip[ND_W-1:LO_W];
            lo_next   = nd_clip[LO_W-1:0];
        end else if (busy_reg) begin
            step_next = step_reg + 1'b1;
            case (step_reg)
                ST_PID:  qp_next = prod[RCP_P_SH+QP_W-1:RCP_P_SH];
                ST_HIGH: qh_next = prod[RCP_D_SH+QH_W-1:RCP_D_SH];
                // remainder of the high part carries into the low part
                ST_REM:  rem_next = hi_rem[RD_W-1:0];
                ST_LOW: begin
                    ql_next   = prod[RCP_D_SH+QL_W-1:RCP_D_SH];
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= ST_PID;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        np_reg  <= np_next;
        hi_reg  <= hi_next;
        lo_reg  <= lo_next;
        qp_reg  <= qp_next;
        qh_reg  <= qh_next;
        ql_reg  <= ql_next;
        rem_reg <= rem_next;
    end

    assign done    = done_reg;
    assign quo_pid = DIV_W'(qp_reg);
    assign quo_drv = DIV_W'({qh_reg, ql_reg});

    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("divider started while busy");
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg)
        else $error("divider done while still busy");
    a_done_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(done_reg) |-> $past(busy_reg) && $past(step_reg) == ST_LOW)
        else $error("divider done without a full pass");

endmodule
`default_nettype wire

FILE: rtl/core/positional_pid_speed_step.sv
// an accepted transaction runs four multiply-accumulate steps, one setup step,
// the divider pass and one finish step, which waits until the output register is free
// a new setpoint is taken only in idle, after the multiply and divide sequence has finished
// the next setpoint is taken while the previous result waits in the output register
// reset: synchronous active-low aresetn clears gains, actual value, previous error,
// error sum and all control state
`default_nettype none
module positional_pid_speed_step (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_we,
    input  wire logic [pps_pkg::CFG_AW-1:0]          cfg_addr,
    input  wire logic [pps_pkg::GAIN_W-1:0]          cfg_wdata,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [pps_pkg::SET_W-1:0]           s_set_speed,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed [pps_pkg::DRV_W-1:0]         m_drive_value,
    output logic signed [pps_pkg::ACT_W-1:0]         m_pid_value
);
    import pps_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MP   = 3'd1;
    localparam logic [2:0] S_MI   = 3'd2;
    localparam logic [2:0] S_MD   = 3'd3;
    localparam logic [2:0] S_MS   = 3'd4;
    localparam logic [2:0] S_DSET = 3'd5;
    localparam logic [2:0] S_DIV  = 3'd6;
    localparam logic [2:0] S_FIN  = 3'd7;

    localparam logic [DIV_W-1:0] PID_POS_LIM = DIV_W'((64'd1 << (ACT_W - 1)) - 64'd1);
    localparam logic [DIV_W-1:0] PID_NEG_LIM = DIV_W'(64'd1 << (ACT_W - 1));
    localparam logic [DIV_W-1:0] DRV_POS_LIM = DIV_W'((64'd1 << (DRV_W - 1)) - 64'd1);
    localparam logic [DIV_W-1:0] DRV_NEG_LIM = DIV_W'(64'd1 << (DRV_W - 1));
    localparam logic signed [TOT_W:0] TOT_MAX = (TOT_W+1)'((64'd1 << (TOT_W - 1)) - 64'd1);
    localparam logic signed [TOT_W:0] TOT_MIN = -(TOT_W+1)'(64'd1 << (TOT_W - 1));

    logic [2:0]              state_reg, state_next;
    logic [GAIN_W-1:0]       gp_reg, gi_reg, gd_reg;
    logic signed [ACT_W-1:0] actual_reg;
    logic signed [PREV_W-1:0] prev_err_reg;
    logic signed [TOT_W-1:0] total_reg;
    logic signed [ERR_W-1:0] err_reg;
    logic signed [DIFF_W-1:0] diff_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic                    pneg_reg, dneg_reg;
    logic                    m_valid_reg, m_valid_next;
    logic signed [DRV_W-1:0] drive_reg;
    logic signed [ACT_W-1:0] pid_out_reg;

    logic                    s_fire;
    logic                    out_free;
    logic signed [ERR_W-1:0] err_c;
    logic signed [DIFF_W-1:0] diff_c;
    logic signed [TOT_W:0]   tot_wide;
    logic signed [TOT_W-1:0] tot_c;

    mac_ctl_t                mac_ctl;
    logic signed [SUM_W-1:0] mac_a;
    logic signed [MUL_B_W-1:0] mac_b;
    logic signed [ACC_W-1:0] mac_add;
    logic signed [ACC_W-1:0] acc;

    logic                    div_start;
    logic                    div_done;
    logic [DIV_W-1:0]        dvd_pid, dvd_drv;
    logic [DIV_W-1:0]        quo_pid, quo_drv;
    logic [SUM_W-1:0]        sum_u;
    logic [DIV_W-1:0]        num_u;

    logic signed [ACT_W-1:0] pid_c;
    logic signed [DRV_W-1:0] drive_c;

    assign s_ready  = (state_reg == S_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // error, derivative and saturating error sum at acceptance
    assign err_c    = ERR_W'($signed({1'b0, s_set_speed})) - ERR_W'(actual_reg);
    assign diff_c   = DIFF_W'(err_c) - prev_err_reg;
    assign tot_wide = (TOT_W+1)'(total_reg) + (TOT_W+1)'(err_c);
    always_comb begin
        if (tot_wide > TOT_MAX) begin
            tot_c = TOT_W'(TOT_MAX);
        end else if (tot_wide < TOT_MIN) begin
            tot_c = TOT_W'(TOT_MIN);
        end else begin
            tot_c = tot_wide[TOT_W-1:0];
        end
    end

    // operand selection for the shared multiplier
    always_comb begin
        mac_ctl = '0;
        mac_a   = '0;
        mac_b   = '0;
        mac_add = '0;
        case (state_reg)
            S_MP: begin
                mac_ctl.load = 1'b1;
                mac_a = SUM_W'(err_reg);
                mac_b = $signed({1'b0, gp_reg});
            end
            S_MI: begin
                mac_ctl.accum = 1'b1;
                mac_a = SUM_W'(total_reg);
                mac_b = $signed({1'b0, gi_reg});
            end
            S_MD: begin
                mac_ctl.accum = 1'b1;
                mac_a = SUM_W'(diff_reg);
                mac_b = $signed({1'b0, gd_reg});
            end
            S_MS: begin
                mac_ctl.load = 1'b1;
                mac_a = acc[SUM_W-1:0];
                mac_b = $signed(SCALE_NUM);
                mac_add = $signed(DRV_OFS);
            end
            default: begin
                mac_ctl = '0;
            end
        endcase
    end

    pps_mac u_mac (
        .aclk   (aclk),
        .ctl    (mac_ctl),
        .op_a   (mac_a),
        .op_b   (mac_b),
        .addend (mac_add),
        .acc    (acc)
    );

    // magnitudes for truncation toward zero
    assign sum_u   = sum_reg[SUM_W-1] ? (~sum_reg + 1'b1) : sum_reg;
    assign num_u   = acc[NUM_W-1] ? (~acc[NUM_W-1:0] + 1'b1) : acc[NUM_W-1:0];
    assign dvd_pid = DIV_W'(sum_u);
    assign dvd_drv = num_u;

    assign div_start = (state_reg == S_DSET);

    pps_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dvd_pid (dvd_pid),
        .dvd_drv (dvd_drv),
        .done    (div_done),
        .quo_pid (quo_pid),
        .quo_drv (quo_drv)
    );

    // sign and saturation of the quotients
    always_comb begin
        if (pneg_reg) begin
            pid_c = (quo_pid > PID_NEG_LIM) ? ACT_W'(PID_NEG_LIM)
                                            : (~quo_pid[ACT_W-1:0] + 1'b1);
        end else begin
            pid_c = (quo_pid > PID_POS_LIM) ? ACT_W'(PID_POS_LIM) : quo_pid[ACT_W-1:0];
        end
        if (dneg_reg) begin
            drive_c = (quo_drv > DRV_NEG_LIM) ? DRV_W'(DRV_NEG_LIM)
                                              : (~quo_drv[DRV_W-1:0] + 1'b1);
        end else begin
            drive_c = (quo_drv > DRV_POS_LIM) ? DRV_W'(DRV_POS_LIM) : quo_drv[DRV_W-1:0];
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (s_fire) state_next = S_MP;
            S_MP:   state_next = S_MI;
            S_MI:   state_next = S_MD;
            S_MD:   state_next = S_MS;
            S_MS:   state_next = S_DSET;
            S_DSET: state_next = S_DIV;
            S_DIV:  if (div_done) state_next = S_FIN;
            S_FIN:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (state_reg == S_FIN && out_free) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_valid_reg  <= 1'b0;
            gp_reg       <= '0;
            gi_reg       <= '0;
            gd_reg       <= '0;
            actual_reg   <= '0;
            prev_err_reg <= '0;
            total_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                case (cfg_addr)
                    REG_GAIN_PROP:  gp_reg <= cfg_wdata;
                    REG_GAIN_INTEG: gi_reg <= cfg_wdata;
                    REG_GAIN_DERIV: gd_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (s_fire) begin
                prev_err_reg <= PREV_W'(err_c);
                total_reg    <= tot_c;
            end
            if (state_reg == S_FIN && out_free) begin
                actual_reg <= pid_c;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            err_reg  <= err_c;
            diff_reg <= diff_c;
        end
        if (state_reg == S_MS) begin
            sum_reg <= acc[SUM_W-1:0];
        end
        if (state_reg == S_DSET) begin
            pneg_reg <= sum_reg[SUM_W-1];
            dneg_reg <= acc[NUM_W-1];
        end
        if (state_reg == S_FIN && out_free) begin
            drive_reg   <= drive_c;
            pid_out_reg <= pid_c;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_drive_value = drive_reg;
    assign m_pid_value   = pid_out_reg;

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> state_reg == S_MP)
        else $error("accepted transaction did not start the multiply sequence");
    a_result_from_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == S_FIN)
        else $error("result appeared outside the finish step");
    a_pid_fed_back: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_pid_value == actual_reg)
        else $error("pending pid value differs from stored actual value");
    a_div_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == S_DIV)
        else $error("divider finished outside the divide step");

endmodule
`default_nettype wire
